@@ design/qcp_pkg.sv @@
// ----------------------------------------------------------------------------
// qcp_pkg: shared definitions for the quarter circle point generator
// Constants, widths, the controller state type and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package qcp_pkg;

  // Largest radius; larger requests saturate to it.
  localparam int MAX_RADIUS   = 44;
  // Number of octant heights that can be stored.
  localparam int OCTANT_DEPTH = 32;

  // Field and internal widths.
  localparam int COORD_W = 6;
  localparam int ADDR_W  = $clog2(OCTANT_DEPTH);
  localparam int CNT_W   = $clog2(OCTANT_DEPTH + 1);
  localparam int DEC_W   = 10;
  localparam int Y_W     = COORD_W + 1;

  // Decision variable constants of the midpoint recurrence.
  localparam int DEC_INIT      = 3;
  localparam int DEC_STEP_INC  = 6;
  localparam int DEC_STEP_DIAG = 10;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_MIR_FETCH,
    ST_MIR_EMIT
  } qcp_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take a new radius and start the walk
    logic walk_step;  // emit the current octant point and advance
    logic mir_fetch;  // read the last stored height
    logic mir_emit;   // emit the mirrored point and read the next one
  } qcp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_more;   // x is not above y and the store has room
    logic count_zero;  // mirror pass is on its last entry
    logic slot_free;   // output register can take a point this cycle
  } qcp_status_t;

endpackage

`default_nettype wire

@@ design/qcp_radius_if.sv @@
// ----------------------------------------------------------------------------
// qcp_radius_if: radius input channel
// Valid/ready channel that carries one radius per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface qcp_radius_if;
  logic                        valid;
  logic                        ready;
  logic [qcp_pkg::COORD_W-1:0] radius;

  modport source (output valid, output radius, input ready);
  modport sink   (input valid, input radius, output ready);
endinterface

`default_nettype wire

@@ design/qcp_point_if.sv @@
// ----------------------------------------------------------------------------
// qcp_point_if: raster point output channel
// Valid/ready channel that carries one point per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface qcp_point_if;
  logic                        valid;
  logic                        ready;
  logic [qcp_pkg::COORD_W-1:0] point_x;
  logic [qcp_pkg::COORD_W-1:0] point_y;
  logic                        last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

`default_nettype wire

@@ design/quarter_circle_points.sv @@
// ----------------------------------------------------------------------------
// quarter_circle_points: raster points of a quarter circle
// Takes one radius per transaction and emits the points of a quarter circle
// with the midpoint decision variable, octant first, then its mirror image.
//
//   channel    modport  direction  payload
//   radius_i   sink     in         radius
//   point_o    source   out        point_x, point_y, last_point
//
// A radius with n octant points (n at most 32) gives 2n point transactions.
// From acceptance to the next acceptance the radius passes through the idle
// state that takes the radius, n walk steps, a walk state that ends the walk,
// one store read before the mirror pass and n mirror steps; the registered
// read of the height store sets the extra read step.
// A new radius is accepted only while idle; a stalled output holds the whole
// walk or mirror pass. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module quarter_circle_points (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  qcp_radius_if.sink      radius_i,
  qcp_point_if.source     point_o
);

  qcp_pkg::qcp_cmd_t    cmd;
  qcp_pkg::qcp_status_t status;
  logic                 in_ready;
  logic                 pt_valid;
  logic                 pt_last;
  logic [qcp_pkg::COORD_W-1:0] pt_x, pt_y;

  // Sequencing controller.
  qcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (radius_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Coordinate datapath with height store and output register.
  qcp_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .radius_i      (radius_i.radius),
    .cmd_i         (cmd),
    .status_o      (status),
    .point_ready_i (point_o.ready),
    .point_valid_o (pt_valid),
    .point_x_o     (pt_x),
    .point_y_o     (pt_y),
    .last_point_o  (pt_last)
  );

  // Channel connections.
  assign radius_i.ready     = in_ready;
  assign point_o.valid      = pt_valid;
  assign point_o.point_x    = pt_x;
  assign point_o.point_y    = pt_y;
  assign point_o.last_point = pt_last;

endmodule

`default_nettype wire

@@ design/qcp_ram.sv @@
// ----------------------------------------------------------------------------
// qcp_ram: generic single-port RAM
// One access per cycle, write or read, with registered read data that holds
// until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module qcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array and read register.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/qcp_ctrl.sv @@
// ----------------------------------------------------------------------------
// qcp_ctrl: sequencing controller
// Steps through idle, the octant walk and the mirror pass, and issues at most
// one command per cycle to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module qcp_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire qcp_pkg::qcp_status_t status_i,
  output qcp_pkg::qcp_cmd_t         cmd_o
);

  qcp_pkg::qcp_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qcp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      qcp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = qcp_pkg::ST_WALK;
        end
      end
      qcp_pkg::ST_WALK: begin
        // The first point past the diagonal is dropped, no slot needed.
        if (!status_i.walk_more) begin
          state_d = qcp_pkg::ST_MIR_FETCH;
        end else if (status_i.slot_free) begin
          cmd_o.walk_step = 1'b1;
        end
      end
      qcp_pkg::ST_MIR_FETCH: begin
        cmd_o.mir_fetch = 1'b1;
        state_d         = qcp_pkg::ST_MIR_EMIT;
      end
      qcp_pkg::ST_MIR_EMIT: begin
        if (status_i.slot_free) begin
          cmd_o.mir_emit = 1'b1;
          if (status_i.count_zero) begin
            state_d = qcp_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = qcp_pkg::ST_IDLE;
      end
    endcase
  end

  // The mirror fetch is only entered from the walk.
  a_fetch_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qcp_pkg::ST_MIR_FETCH) |-> $past(state_q) == qcp_pkg::ST_WALK)
    else $error("mirror fetch not entered from the walk");

  // A new walk always starts with a point to emit.
  a_load_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == qcp_pkg::ST_WALK && status_i.walk_more))
    else $error("new walk did not start with a point to emit");

  // Only one command at a time.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.walk_step, cmd_o.mir_fetch, cmd_o.mir_emit}))
    else $error("more than one datapath command");

endmodule

`default_nettype wire

@@ design/qcp_datapath.sv @@
// ----------------------------------------------------------------------------
// qcp_datapath: midpoint circle datapath
// Holds the walk coordinates, the decision variable, the point counter, the
// height store and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qcp_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic        [qcp_pkg::COORD_W-1:0]   radius_i,
  input  wire qcp_pkg::qcp_cmd_t                    cmd_i,
  output qcp_pkg::qcp_status_t                      status_o,
  input  wire logic                                 point_ready_i,
  output logic                                      point_valid_o,
  output logic             [qcp_pkg::COORD_W-1:0]   point_x_o,
  output logic             [qcp_pkg::COORD_W-1:0]   point_y_o,
  output logic                                      last_point_o
);

  localparam int DEC_W = qcp_pkg::DEC_W;

  logic        [qcp_pkg::COORD_W-1:0] x_q, x_d;
  logic signed [qcp_pkg::Y_W-1:0]     y_q, y_d;
  logic signed [DEC_W-1:0]            dec_q, dec_d;
  logic        [qcp_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic        [qcp_pkg::CNT_W-1:0]   cnt_m1;

  logic        [qcp_pkg::COORD_W-1:0] rad_sat;
  logic signed [DEC_W-1:0]            dec_init, x_ext, y_ext, dec_inc, dec_diag;

  logic                               out_valid_q, out_valid_d;
  logic        [qcp_pkg::COORD_W-1:0] out_x_q, out_y_q;
  logic                               out_last_q;

  logic                               ram_we, ram_re;
  logic        [qcp_pkg::ADDR_W-1:0]  ram_addr;
  logic        [qcp_pkg::COORD_W-1:0] ram_rdata;

  // Radius saturation and starting decision value 3 - 2r.
  assign rad_sat  = (radius_i > qcp_pkg::COORD_W'(qcp_pkg::MAX_RADIUS))
                  ? qcp_pkg::COORD_W'(qcp_pkg::MAX_RADIUS) : radius_i;
  assign dec_init = $signed(DEC_W'(qcp_pkg::DEC_INIT))
                  - $signed(DEC_W'({rad_sat, 1'b0}));

  // Decision updates for the straight and the diagonal step.
  assign x_ext    = $signed(DEC_W'(x_q));
  assign y_ext    = DEC_W'(y_q);
  assign dec_inc  = dec_q + (x_ext <<< 2) + $signed(DEC_W'(qcp_pkg::DEC_STEP_INC));
  assign dec_diag = dec_q + ((x_ext - y_ext) <<< 2)
                  + $signed(DEC_W'(qcp_pkg::DEC_STEP_DIAG));

  assign cnt_m1 = cnt_q - 1'b1;

  // Status toward the controller.
  assign status_o.walk_more  = ($signed({1'b0, x_q}) <= y_q)
                             && (cnt_q < qcp_pkg::CNT_W'(qcp_pkg::OCTANT_DEPTH));
  assign status_o.count_zero = (cnt_q == '0);
  assign status_o.slot_free  = !out_valid_q || point_ready_i;

  // Walk registers and the shared point counter.
  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    dec_d = dec_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      x_d   = '0;
      y_d   = qcp_pkg::Y_W'(rad_sat);
      dec_d = dec_init;
      cnt_d = '0;
    end else if (cmd_i.walk_step) begin
      x_d   = x_q + 1'b1;
      cnt_d = cnt_q + 1'b1;
      if (dec_q < 0) begin
        dec_d = dec_inc;
      end else begin
        dec_d = dec_diag;
        y_d   = y_q - 1'b1;
      end
    end else if (cmd_i.mir_fetch || (cmd_i.mir_emit && !status_o.count_zero)) begin
      cnt_d = cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      y_q   <= '0;
      dec_q <= '0;
      cnt_q <= '0;
    end else begin
      x_q   <= x_d;
      y_q   <= y_d;
      dec_q <= dec_d;
      cnt_q <= cnt_d;
    end
  end

  // Height store: written during the walk, read back in reverse.
  assign ram_we   = cmd_i.walk_step;
  assign ram_re   = cmd_i.mir_fetch || (cmd_i.mir_emit && !status_o.count_zero);
  assign ram_addr = cmd_i.walk_step ? cnt_q[qcp_pkg::ADDR_W-1:0]
                                    : cnt_m1[qcp_pkg::ADDR_W-1:0];

  qcp_ram #(
    .WIDTH (qcp_pkg::COORD_W),
    .DEPTH (qcp_pkg::OCTANT_DEPTH)
  ) u_heights (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (y_q[qcp_pkg::COORD_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.walk_step || cmd_i.mir_emit) begin
      out_valid_d = 1'b1;
    end else if (point_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_step) begin
      out_x_q    <= x_q;
      out_y_q    <= y_q[qcp_pkg::COORD_W-1:0];
      out_last_q <= 1'b0;
    end else if (cmd_i.mir_emit) begin
      out_x_q    <= ram_rdata;
      out_y_q    <= cnt_q[qcp_pkg::COORD_W-1:0];
      out_last_q <= status_o.count_zero;
    end
  end

  assign point_valid_o = out_valid_q;
  assign point_x_o     = out_x_q;
  assign point_y_o     = out_y_q;
  assign last_point_o  = out_last_q;

  // The counter never passes the store depth.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= qcp_pkg::CNT_W'(qcp_pkg::OCTANT_DEPTH))
    else $error("point counter beyond store depth");

  // The walk stops at most one row below zero.
  a_y_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    y_q >= -7'sd1)
    else $error("walk y fell below minus one");

  // A point is only loaded into a free output slot.
  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.walk_step || cmd_i.mir_emit) |-> status_o.slot_free)
    else $error("point loaded over a pending transaction");

  // A walk step is only issued while the octant has points left.
  a_step_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_step |-> status_o.walk_more)
    else $error("walk step issued past the octant end");

endmodule

`default_nettype wire
